// ===== src/smsup_pkg.sv =====
// shared types, constants and transition rules for the safety mode supervisor
// no dependencies; imported by every module of the block except smsup_ram
package smsup_pkg;

    localparam int LOG_DEPTH  = 16;
    localparam int LOG_AW     = $clog2(LOG_DEPTH);
    localparam int LOG_FW     = $clog2(LOG_DEPTH + 1);
    localparam int IDX_W      = 4;
    localparam int SUM_W      = ((LOG_AW > IDX_W) ? LOG_AW : IDX_W) + 1;
    localparam int MS_PER_S   = 1000;
    localparam int SUB_W      = $clog2(MS_PER_S);
    localparam int UPTIME_W   = 23;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_REQUEST,
        KIND_FORCE_SAFE,
        KIND_TICK,
        KIND_READ_HIST
    } kind_t;

    typedef enum logic [3:0] {
        ST_BOOT,
        ST_INIT,
        ST_SELF_TEST,
        ST_READY,
        ST_RUNNING,
        ST_WARNING,
        ST_FAULT,
        ST_SAFE,
        ST_SLEEP,
        ST_CALIB
    } state_t;

    localparam logic [3:0] ST_COUNT = 4'd10;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_REJECT,
        STATUS_NO_ENTRY
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_RELAY,
        ACT_SAFE
    } action_t;

    typedef enum logic [2:0] {
        OP_REQUEST,
        OP_INVALID,
        OP_FORCE_SAFE,
        OP_TICK,
        OP_READ
    } op_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       target_state;
        logic [7:0]       reason_code;
        logic [IDX_W-1:0] history_index;
    } item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [3:0]          state_now;
        logic                is_operational;
        logic                is_faulted;
        logic [1:0]          output_action;
        logic [31:0]         state_duration_ms;
        logic [UPTIME_W-1:0] uptime_seconds;
        logic [3:0]          hist_from;
        logic [3:0]          hist_to;
        logic [31:0]         hist_time;
        logic [7:0]          hist_reason;
    } result_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t              op;
        state_t           target;
        logic [7:0]       reason;
        logic [IDX_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  from_state;
        logic [3:0]  to_state;
        logic [31:0] time_ms;
        logic [7:0]  reason;
    } log_t;

    localparam int LOG_W = $bits(log_t);

    function automatic logic allowed(state_t src, state_t dst);
        logic ok;
        ok = 1'b0;
        if (src == ST_SAFE)
        begin
            ok = 1'b0;
        end
        else if (dst == ST_SAFE)
        begin
            ok = 1'b1;
        end
        else if (dst == ST_FAULT)
        begin
            ok = (src != ST_BOOT);
        end
        else
        begin
            case (src)
                ST_BOOT:      ok = (dst == ST_INIT);
                ST_INIT:      ok = (dst == ST_SELF_TEST);
                ST_SELF_TEST: ok = (dst == ST_READY);
                ST_READY:     ok = dst inside {ST_RUNNING, ST_CALIB, ST_SLEEP};
                ST_RUNNING:   ok = dst inside {ST_READY, ST_WARNING, ST_SLEEP};
                ST_WARNING:   ok = dst inside {ST_RUNNING, ST_SLEEP};
                ST_FAULT:     ok = (dst == ST_READY);
                ST_CALIB:     ok = (dst == ST_READY);
                ST_SLEEP:     ok = dst inside {ST_READY, ST_INIT};
                default:      ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    function automatic action_t action_for(state_t s);
        action_t a;
        case (s)
            ST_FAULT, ST_SLEEP: a = ACT_RELAY;
            ST_SAFE:            a = ACT_SAFE;
            default:            a = ACT_NONE;
        endcase
        return a;
    endfunction

endpackage

// ===== src/smsup_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module smsup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/smsup_front.sv =====
// front end: takes input beats, classifies them and queues commands for the back end
// depends on smsup_pkg
module smsup_front
    import smsup_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  cmd_valid,
    output cmd_t  cmd,
    input  logic  cmd_pop
);

    cmd_t               cmd_in;
    cmd_t               q_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] count_reg, count_next;
    logic               push_ok;
    logic               pop_ok;

    always_comb
    begin
        cmd_in.target = state_t'(item.target_state);
        cmd_in.reason = item.reason_code;
        cmd_in.index  = item.history_index;
        case (item.kind)
            KIND_REQUEST:
                cmd_in.op = (item.target_state >= ST_COUNT) ? OP_INVALID : OP_REQUEST;
            KIND_FORCE_SAFE: cmd_in.op = OP_FORCE_SAFE;
            KIND_TICK:       cmd_in.op = OP_TICK;
            KIND_READ_HIST:  cmd_in.op = OP_READ;
            default:         cmd_in.op = OP_INVALID;
        endcase
    end

    assign full      = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== src/smsup_back.sv =====
// back end: supervisor state, millisecond clock, transition log and result assembly
// depends on smsup_pkg and smsup_ram
module smsup_back
    import smsup_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_pop,
    input  logic [RESQ_CW-1:0] resq_level,
    output logic               res_valid,
    output result_t            res
);

    localparam int FLW = RESQ_CW + 1;

    state_t              cur_reg, cur_next;
    logic [31:0]         enter_reg, enter_next;
    logic [31:0]         clock_reg, clock_next;
    logic [UPTIME_W-1:0] sec_reg, sec_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic [LOG_AW-1:0]   head_reg, head_next;
    logic [LOG_FW-1:0]   fill_reg, fill_next;
    logic                s2_valid_reg;
    status_t             s2_status_reg;
    action_t             s2_action_reg;
    logic                s2_hit_reg;

    logic                exec_en;
    logic [FLW-1:0]      in_flight;
    status_t             status;
    action_t             action;
    logic                hit;
    logic                trans_en;
    state_t              trans_to;
    logic [LOG_AW-1:0]   start;
    logic [SUM_W-1:0]    sum;
    logic [LOG_AW-1:0]   raddr;
    logic                in_range;
    log_t                log_wr;
    logic [LOG_W-1:0]    ram_rdata;
    log_t                log_rd;

    // a beat may only start when the result queue is sure to have a slot for it
    assign in_flight = FLW'(resq_level) + FLW'(s2_valid_reg);
    assign exec_en   = cmd_valid && (in_flight < FLW'(RESQ_DEPTH));
    assign cmd_pop   = exec_en;

    // oldest-first position into ring address
    assign start    = (fill_reg == LOG_FW'(LOG_DEPTH)) ? head_reg : '0;
    assign sum      = SUM_W'(start) + SUM_W'(cmd.index);
    assign raddr    = (sum >= SUM_W'(LOG_DEPTH)) ? LOG_AW'(sum - SUM_W'(LOG_DEPTH))
                                                  : LOG_AW'(sum);
    assign in_range = SUM_W'(cmd.index) < SUM_W'(fill_reg);

    always_comb
    begin
        cur_next   = cur_reg;
        enter_next = enter_reg;
        clock_next = clock_reg;
        sec_next   = sec_reg;
        sub_next   = sub_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        status     = STATUS_OK;
        action     = ACT_NONE;
        hit        = 1'b0;
        trans_en   = 1'b0;
        trans_to   = ST_SAFE;
        case (cmd.op)
            OP_REQUEST:
            begin
                if (cmd.target != cur_reg)
                begin
                    if (allowed(cur_reg, cmd.target))
                    begin
                        trans_en = 1'b1;
                        trans_to = cmd.target;
                    end
                    else
                    begin
                        status = STATUS_REJECT;
                    end
                end
            end
            OP_INVALID:
            begin
                status = STATUS_REJECT;
            end
            OP_FORCE_SAFE:
            begin
                trans_en = 1'b1;
                trans_to = ST_SAFE;
            end
            OP_TICK:
            begin
                clock_next = clock_reg + 32'd1;
                // seconds follow the wrapped millisecond clock
                if (&clock_reg)
                begin
                    sec_next = '0;
                    sub_next = '0;
                end
                else if (sub_reg == SUB_W'(MS_PER_S - 1))
                begin
                    sec_next = sec_reg + 1'b1;
                    sub_next = '0;
                end
                else
                begin
                    sub_next = sub_reg + 1'b1;
                end
            end
            OP_READ:
            begin
                if (in_range)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    status = STATUS_NO_ENTRY;
                end
            end
            default:
            begin
                status = STATUS_REJECT;
            end
        endcase
        if (trans_en)
        begin
            cur_next   = trans_to;
            enter_next = clock_reg;
            head_next  = (head_reg == LOG_AW'(LOG_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (fill_reg != LOG_FW'(LOG_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
            action = action_for(trans_to);
        end
    end

    always_comb
    begin
        log_wr.from_state = cur_reg;
        log_wr.to_state   = trans_to;
        log_wr.time_ms    = clock_reg;
        log_wr.reason     = cmd.reason;
    end

    smsup_ram #(
        .WIDTH (LOG_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (exec_en && trans_en),
        .waddr (head_reg),
        .wdata (log_wr),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= ST_BOOT;
            enter_reg    <= '0;
            clock_reg    <= '0;
            sec_reg      <= '0;
            sub_reg      <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= exec_en;
            if (exec_en)
            begin
                cur_reg   <= cur_next;
                enter_reg <= enter_next;
                clock_reg <= clock_next;
                sec_reg   <= sec_next;
                sub_reg   <= sub_next;
                head_reg  <= head_next;
                fill_reg  <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            s2_status_reg <= status;
            s2_action_reg <= action;
            s2_hit_reg    <= hit;
        end
    end

    // second stage: state registers already hold the values after this beat
    assign log_rd    = log_t'(ram_rdata);
    assign res_valid = s2_valid_reg;

    always_comb
    begin
        res.status            = s2_status_reg;
        res.state_now         = cur_reg;
        res.is_operational    = cur_reg inside {ST_READY, ST_RUNNING, ST_WARNING, ST_CALIB};
        res.is_faulted        = cur_reg inside {ST_FAULT, ST_SAFE};
        res.output_action     = s2_action_reg;
        res.state_duration_ms = clock_reg - enter_reg;
        res.uptime_seconds    = sec_reg;
        res.hist_from         = s2_hit_reg ? log_rd.from_state : '0;
        res.hist_to           = s2_hit_reg ? log_rd.to_state : '0;
        res.hist_time         = s2_hit_reg ? log_rd.time_ms : '0;
        res.hist_reason       = s2_hit_reg ? log_rd.reason : '0;
    end

endmodule

// ===== src/smsup_resq.sv =====
// result queue between the back end and the result port
// depends on smsup_pkg
module smsup_resq
    import smsup_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  result_t            wr_data,
    output logic [RESQ_CW-1:0] level,
    output logic               empty,
    input  logic               pop,
    output result_t            result
);

    result_t            q_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RESQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RESQ_CW-1:0] count_reg, count_next;
    logic               pop_ok;

    assign level  = count_reg;
    assign empty  = (count_reg == '0);
    assign result = q_reg[rd_ptr_reg];
    assign pop_ok = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/safety_mode_supervisor.sv =====
// top level of the safety mode supervisor: front end, back end and result queue
// depends on smsup_pkg, smsup_front, smsup_back, smsup_resq
//
//   channel  | handshake            | beat
//   ---------+----------------------+------------------------------
//   input    | push / full          | item   (item_t, one command)
//   result   | pop / empty          | result (result_t, one per item)
//
// one item per cycle sustained while results are taken; a result reaches the result port
// at the earliest once its input beat has passed the command queue, then execute with the log read,
// then the result queue.
// the log ram read and the state update share the execute cycle, which sets the rate.
// reset clears state, clock, ring pointers and both queues; log entries are
// never read before they are written, so the ram needs no clearing.
// a stalled result side fills the result queue, then the command queue, then raises full.
module safety_mode_supervisor
    import smsup_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;
    logic [RESQ_CW-1:0] resq_level;
    logic               res_valid;
    result_t            res;

    smsup_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    smsup_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .resq_level (resq_level),
        .res_valid  (res_valid),
        .res        (res)
    );

    smsup_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .level   (resq_level),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== src/smsup_checker.sv =====
// port-level checks on the safety mode supervisor, bound to the top level
// depends on smsup_pkg and safety_mode_supervisor
module smsup_props
    import smsup_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // entering safe mode always leaves the block in safe mode and faulted
    a_safe_action: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.output_action == ACT_SAFE) |->
            (result.state_now == ST_SAFE && result.is_faulted))
        else $error("emergency-safe action without safe mode");

    // relay opens only on entry to fault or sleep
    a_relay_action: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.output_action == ACT_RELAY) |->
            (result.state_now == ST_FAULT || result.state_now == ST_SLEEP))
        else $error("relay action in wrong state");

    // a failed beat carries no history and no action
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STATUS_OK) |->
            (result.hist_time == '0 && result.hist_reason == '0 &&
             result.hist_from == '0 && result.hist_to == '0 &&
             result.output_action == ACT_NONE))
        else $error("failed beat with history or action");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

endmodule

bind safety_mode_supervisor smsup_props u_smsup_props (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ===== dv/smsup_checker.sv =====
// checker for the safety mode supervisor: watches the item and result channels,
// keeps its own model of the supervisor state and history ring, compares each result
// depends on smsup_pkg
module smsup_checker
    import smsup_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic    full,
    input  item_t   item,
    input  logic    empty,
    input  logic    pop,
    input  result_t result,
    output int      errors,
    output int      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [3:0]  mode_now;
    logic [31:0] ms_clock;
    logic [31:0] entered_at;
    int          ring_wr;
    int          ring_used;
    log_t        ring [LOG_DEPTH];
    result_t     replies_due [$];

    task automatic flag_error(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic logic may_move(logic [3:0] src, logic [3:0] dst);
        logic [15:0] reach;
        reach = '0;
        case (src)
            ST_BOOT:      reach[ST_INIT] = 1'b1;
            ST_INIT:      reach[ST_SELF_TEST] = 1'b1;
            ST_SELF_TEST: reach[ST_READY] = 1'b1;
            ST_READY:
            begin
                reach[ST_RUNNING] = 1'b1;
                reach[ST_CALIB]   = 1'b1;
                reach[ST_SLEEP]   = 1'b1;
            end
            ST_RUNNING:
            begin
                reach[ST_READY]   = 1'b1;
                reach[ST_WARNING] = 1'b1;
                reach[ST_SLEEP]   = 1'b1;
            end
            ST_WARNING:
            begin
                reach[ST_RUNNING] = 1'b1;
                reach[ST_SLEEP]   = 1'b1;
            end
            ST_FAULT:     reach[ST_READY] = 1'b1;
            ST_CALIB:     reach[ST_READY] = 1'b1;
            ST_SLEEP:
            begin
                reach[ST_READY] = 1'b1;
                reach[ST_INIT]  = 1'b1;
            end
            default:      reach = '0;
        endcase
        // fault is reachable from everywhere but boot, safe mode from everywhere
        if (src != ST_BOOT)
        begin
            reach[ST_FAULT] = 1'b1;
        end
        reach[ST_SAFE] = 1'b1;
        // safe mode is a dead end
        if (src == ST_SAFE)
        begin
            reach = '0;
        end
        return reach[dst];
    endfunction

    task automatic enter_mode(input logic [3:0] dst, input logic [7:0] why);
        log_t ent;
        ent.from_state = mode_now;
        ent.to_state   = dst;
        ent.time_ms    = ms_clock;
        ent.reason     = why;
        ring[ring_wr]  = ent;
        ring_wr = (ring_wr + 1) % LOG_DEPTH;
        if (ring_used < LOG_DEPTH)
        begin
            ring_used++;
        end
        mode_now   = dst;
        entered_at = ms_clock;
    endtask

    task automatic step_supervisor(input item_t it, output result_t r);
        logic [3:0] tgt;
        int         pos;
        log_t       ent;
        r   = '0;
        tgt = it.target_state;
        case (it.kind)
            KIND_REQUEST:
            begin
                if (tgt >= ST_COUNT)
                begin
                    r.status = STATUS_REJECT;
                end
                else if (tgt == mode_now)
                begin
                    r.status = STATUS_OK;
                end
                else if (!may_move(mode_now, tgt))
                begin
                    r.status = STATUS_REJECT;
                end
                else
                begin
                    enter_mode(tgt, it.reason_code);
                    if (tgt == ST_FAULT || tgt == ST_SLEEP)
                    begin
                        r.output_action = ACT_RELAY;
                    end
                    else if (tgt == ST_SAFE)
                    begin
                        r.output_action = ACT_SAFE;
                    end
                end
            end
            KIND_FORCE_SAFE:
            begin
                enter_mode(ST_SAFE, it.reason_code);
                r.output_action = ACT_SAFE;
            end
            KIND_TICK:
            begin
                ms_clock = ms_clock + 32'd1;
            end
            default:
            begin
                if (int'(it.history_index) < ring_used)
                begin
                    // oldest entry sits at the write pointer once the ring is full
                    pos = ((ring_used < LOG_DEPTH) ? 0 : ring_wr) + int'(it.history_index);
                    ent = ring[pos % LOG_DEPTH];
                    r.hist_from   = ent.from_state;
                    r.hist_to     = ent.to_state;
                    r.hist_time   = ent.time_ms;
                    r.hist_reason = ent.reason;
                end
                else
                begin
                    r.status = STATUS_NO_ENTRY;
                end
            end
        endcase
        r.state_now      = mode_now;
        r.is_operational = (mode_now == ST_READY) || (mode_now == ST_RUNNING) ||
                           (mode_now == ST_WARNING) || (mode_now == ST_CALIB);
        r.is_faulted     = (mode_now == ST_FAULT) || (mode_now == ST_SAFE);
        r.state_duration_ms = ms_clock - entered_at;
        r.uptime_seconds    = UPTIME_W'(ms_clock / MS_PER_S);
    endtask

    task automatic compare_reply(input result_t got, input result_t want);
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("state_now", 32'(got.state_now), 32'(want.state_now));
        check_field("is_operational", 32'(got.is_operational), 32'(want.is_operational));
        check_field("is_faulted", 32'(got.is_faulted), 32'(want.is_faulted));
        check_field("output_action", 32'(got.output_action), 32'(want.output_action));
        check_field("state_duration_ms", got.state_duration_ms, want.state_duration_ms);
        check_field("uptime_seconds", 32'(got.uptime_seconds), 32'(want.uptime_seconds));
        check_field("hist_from", 32'(got.hist_from), 32'(want.hist_from));
        check_field("hist_to", 32'(got.hist_to), 32'(want.hist_to));
        check_field("hist_time", got.hist_time, want.hist_time);
        check_field("hist_reason", 32'(got.hist_reason), 32'(want.hist_reason));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t calc;
        if (!rst_n)
        begin
            mode_now   = ST_BOOT;
            ms_clock   = '0;
            entered_at = '0;
            ring_wr    = 0;
            ring_used  = 0;
            replies_due.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (replies_due.size() == 0)
                begin
                    flag_error("result beat with no item waiting");
                end
                else
                begin
                    compare_reply(result, replies_due.pop_front());
                end
            end
            if (push && !full)
            begin
                step_supervisor(item, calc);
                replies_due.push_back(calc);
            end
            outstanding = replies_due.size();
        end
    end

endmodule

// ===== dv/tb_safety_mode_supervisor.sv =====
// testbench top for the safety mode supervisor: clock, reset, item and pop stimulus
// depends on smsup_pkg, safety_mode_supervisor and smsup_checker
module tb_safety_mode_supervisor
    import smsup_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;
    int      errors;
    int      outstanding;

    state_t  walk;
    int      burst_left;

    safety_mode_supervisor i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    smsup_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t beat_of(kind_t k, logic [3:0] tgt, logic [7:0] why,
                                      logic [3:0] idx);
        item_t b;
        b.kind          = k;
        b.target_state  = tgt;
        b.reason_code   = why;
        b.history_index = idx;
        return b;
    endfunction

    // a target that the current walk position may move to, safe mode left out; any code 0 to 9 if none exists
    function automatic logic [3:0] legal_target();
        logic [3:0] pool [$];
        for (int c = 0; c < ST_COUNT; c++)
        begin
            if (c != ST_SAFE && c != walk && allowed(walk, state_t'(c)))
            begin
                pool.push_back(4'(c));
            end
        end
        if (pool.size() == 0)
        begin
            return 4'($urandom_range(0, 9));
        end
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // random target, never safe mode, invalid codes included
    function automatic logic [3:0] noisy_target();
        logic [3:0] t;
        t = 4'($urandom_range(0, 15));
        if (t == ST_SAFE)
        begin
            t = ST_COUNT;
        end
        return t;
    endfunction

    task automatic follow_walk(input item_t it);
        if (it.kind == KIND_FORCE_SAFE)
        begin
            walk = ST_SAFE;
        end
        else if (it.kind == KIND_REQUEST && it.target_state < ST_COUNT &&
                 it.target_state != walk && allowed(walk, state_t'(it.target_state)))
        begin
            walk = state_t'(it.target_state);
        end
    endtask

    // one item beat, in bursts with random gaps; called and returns at a falling edge
    task automatic issue(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        item <= it;
        follow_walk(it);
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic request(input logic [3:0] tgt, input logic [7:0] why);
        issue(beat_of(KIND_REQUEST, tgt, why, 4'($urandom_range(0, 15))));
    endtask

    task automatic read_back(input logic [3:0] idx);
        issue(beat_of(KIND_READ_HIST, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      idx));
    endtask

    task automatic tick();
        issue(beat_of(KIND_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15))));
    endtask

    initial
    begin : stimulus
        int sent;
        int pick;
        int n;
        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        walk  = ST_BOOT;
        burst_left = 0;
        sent = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty ring, invalid codes, same state, rejects, a full walk
        read_back(4'd0);
        issue(beat_of(KIND_REQUEST, 4'd15, 8'hff, 4'hf));
        request(ST_BOOT, 8'h11);
        request(ST_FAULT, 8'h12);
        tick();
        request(ST_INIT, 8'h00);
        request(ST_INIT, 8'h13);
        request(ST_READY, 8'h14);
        tick();
        tick();
        request(ST_SELF_TEST, 8'h21);
        request(ST_READY, 8'h22);
        request(ST_CALIB, 8'h23);
        request(ST_READY, 8'h24);
        request(ST_RUNNING, 8'h25);
        request(ST_WARNING, 8'h26);
        request(ST_FAULT, 8'h27);
        request(ST_READY, 8'h28);
        request(ST_SLEEP, 8'h29);
        request(ST_INIT, 8'h2a);
        issue(beat_of(KIND_REQUEST, ST_COUNT, 8'h55, 4'h0));
        read_back(4'd0);
        read_back(4'd3);
        read_back(4'd15);
        drain();

        // random walk through the legal graph with noise, reads and tick runs
        while (sent < 610)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                n = $urandom_range(1, 12);
                repeat (n) tick();
                sent += n;
            end
            else if (pick < 75)
            begin
                request(legal_target(), 8'($urandom_range(0, 255)));
                sent++;
            end
            else if (pick < 85)
            begin
                request(noisy_target(), 8'($urandom_range(0, 255)));
                sent++;
            end
            else
            begin
                read_back(4'($urandom_range(0, 15)));
                sent++;
            end
        end
        drain();

        // safe mode last, since nothing leaves it
        request(ST_SAFE, 8'($urandom_range(0, 255)));
        issue(beat_of(KIND_FORCE_SAFE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15))));
        issue(beat_of(KIND_FORCE_SAFE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15))));
        repeat (6) request(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        repeat (3) tick();
        repeat (4) read_back(4'($urandom_range(0, 15)));
        drain();
        repeat (10) @(negedge clk);

        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // result side stalls in stretches of different character
    initial
    begin : receiver
        int mode;
        int len;
        int k;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 64);
            for (k = 0; k < len; k++)
            begin
                @(negedge clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 7) == 0);
                    default: pop <= ((k % 6) < 4);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
